// ----- hdl/assert_macros.svh -----
// assertion macros used by the monitor rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked check, masked while reset is held
`define ECDM_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);

// clocked check, also active during reset
`define ECDM_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ----- hdl/ecdm_pkg.sv -----
// package with widths, constants and shared types of the drowsiness monitor
package ecdm_pkg;

    localparam int HISTORY_DEPTH = 100;
    localparam int MAX_EYES      = 4;
    localparam int PCT_SCALE     = 100;

    localparam int THR_W     = 16;
    localparam int CNT_W     = 16;
    localparam int HOLD_W    = 8;
    localparam int SUM_W     = 18;
    localparam int VEC_W     = 3;
    localparam int LEVEL_W   = 7;
    localparam int EYE_W     = 4;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 16;

    localparam int IDX_W  = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
    localparam int FILL_W = $clog2(HISTORY_DEPTH + 1);
    localparam int NUM_W  = $clog2(PCT_SCALE * HISTORY_DEPTH + 1);
    localparam int STEP_W = $clog2(NUM_W + 1);
    localparam int PROD_W = THR_W + EYE_W;

    localparam logic [THR_W-1:0]  EAR_THRESHOLD_RST      = 16'd13107;
    localparam logic [CNT_W-1:0]  CONSECUTIVE_FRAMES_RST = 16'd15;
    localparam logic [HOLD_W-1:0] HOLDOFF_TICKS_RST      = 8'd3;

    localparam logic [CFG_IDX_W-1:0] REG_EAR_THRESHOLD      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CONSECUTIVE_FRAMES = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HOLDOFF_TICKS      = 2'd2;

    localparam logic MODE_FRAME = 1'b0;
    localparam logic MODE_TICK  = 1'b1;

    typedef struct packed {
        logic              start;
        logic [NUM_W-1:0]  num;
        logic [FILL_W-1:0] den;
    } ecdm_div_req_t;

    typedef struct packed {
        logic             busy;
        logic [NUM_W-1:0] quo;
    } ecdm_div_rsp_t;

endpackage

// ----- hdl/ecdm_hist_ram.sv -----
// generic single-write, single-read ram with registered read data
module ecdm_hist_ram #(
    parameter int DEPTH  = 100,
    parameter int WIDTH  = 1,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ----- hdl/ecdm_div.sv -----
// restoring serial divider, one quotient bit per cycle
module ecdm_div
    import ecdm_pkg::*;
(
    input  logic          aclk,
    input  logic          aresetn,
    input  ecdm_div_req_t req,
    output ecdm_div_rsp_t rsp
);

    logic [STEP_W-1:0] step_reg, step_next;
    logic [NUM_W-1:0]  quo_reg, quo_next;
    logic [FILL_W-1:0] rem_reg, rem_next;
    logic [FILL_W-1:0] den_reg, den_next;
    logic [FILL_W:0]   trial;
    logic              ge;

    always_comb begin
        trial     = {rem_reg, quo_reg[NUM_W-1]};
        ge        = trial >= {1'b0, den_reg};
        step_next = step_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        if (req.start) begin
            step_next = STEP_W'(NUM_W);
            quo_next  = req.num;
            rem_next  = '0;
            den_next  = req.den;
        end else if (step_reg != '0) begin
            // remainder stays below the divisor, so the low bits hold it
            rem_next  = ge ? FILL_W'(trial - {1'b0, den_reg}) : trial[FILL_W-1:0];
            quo_next  = {quo_reg[NUM_W-2:0], ge};
            step_next = step_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg <= '0;
        end else begin
            step_reg <= step_next;
        end
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign rsp.busy = step_reg != '0;
    assign rsp.quo  = quo_reg;

endmodule

// ----- hdl/eye_closure_drowsiness_monitor_unit.sv -----
// top level of the eye closure drowsiness monitor
// frame request: accepted in idle, then read, update and divide states; done loads the result register
// tick request: accepted in idle, goes straight to done, which loads the result register and returns to idle
// frame time is set by the serial percentage divider, one quotient bit per cycle
// one request in flight; the output register lets a new request in while a result waits
// aresetn synchronous active low: counters, level and fill cleared, config to defaults
// history ram holds no reset; an entry read back is only used once the ring has been filled
module eye_closure_drowsiness_monitor_unit
    import ecdm_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    // input requests
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic                 s_mode,
    input  logic                 s_face_present,
    input  logic                 s_eyes_detected,
    input  logic [VEC_W-1:0]     s_valid_eye_count,
    input  logic [SUM_W-1:0]     s_ratio_sum,
    // result requests
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic                 m_eyes_closed,
    output logic                 m_drowsy_alarm,
    output logic [LEVEL_W-1:0]   m_drowsiness_level,
    // configuration writes
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_DAT_W-1:0] cfg_wdata
);

    `include "assert_macros.svh"

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_UPDATE,
        ST_DIV,
        ST_DONE
    } state_t;

    state_t state_reg, state_next;

    // configuration
    logic [THR_W-1:0]  ear_thr_reg, ear_thr_next;
    logic [CNT_W-1:0]  consec_reg, consec_next;
    logic [HOLD_W-1:0] holdoff_reg, holdoff_next;

    // captured request payload
    logic              face_reg, face_next;
    logic              eyes_reg, eyes_next;
    logic [VEC_W-1:0]  vcnt_reg, vcnt_next;
    logic [SUM_W-1:0]  sum_reg, sum_next;

    // monitor state
    logic [FILL_W-1:0]  fill_reg, fill_next;
    logic [IDX_W-1:0]   pos_reg, pos_next;
    logic [FILL_W-1:0]  total_reg, total_next;
    logic [CNT_W-1:0]   leaky_reg, leaky_next;
    logic [HOLD_W-1:0]  ticks_reg, ticks_next;
    logic [LEVEL_W-1:0] level_reg, level_next;

    // per-request results
    logic closed_reg, closed_next;
    logic alarm_reg, alarm_next;

    // output register
    logic               m_valid_reg, m_valid_next;
    logic               m_closed_reg, m_closed_next;
    logic               m_alarm_reg, m_alarm_next;
    logic [LEVEL_W-1:0] m_level_reg, m_level_next;

    // history ram and divider hookup
    logic          ram_re, ram_we, ram_rdata;
    ecdm_div_req_t div_req;
    ecdm_div_rsp_t div_rsp;

    // closed judgement helpers
    logic [EYE_W-1:0]  eyes_clamped;
    logic [PROD_W-1:0] thr_scaled;
    logic              judge;

    // ring update helpers
    logic              ring_full;
    logic [FILL_W-1:0] total_drop;
    logic [FILL_W-1:0] total_upd;
    logic [FILL_W-1:0] fill_upd;
    logic [CNT_W-1:0]  leaky_inc;

    ecdm_hist_ram #(
        .DEPTH (HISTORY_DEPTH),
        .WIDTH (1),
        .ADDR_W(IDX_W)
    ) u_hist_ram (
        .aclk (aclk),
        .we   (ram_we),
        .waddr(pos_reg),
        .wdata(closed_reg),
        .re   (ram_re),
        .raddr(pos_reg),
        .rdata(ram_rdata)
    );

    ecdm_div u_div (
        .aclk   (aclk),
        .aresetn(aresetn),
        .req    (div_req),
        .rsp    (div_rsp)
    );

    assign s_ready = state_reg == ST_IDLE;

    // closed rule: eyes missing follows face presence, else average below threshold over at least one valid eye
    always_comb begin
        eyes_clamped = (EYE_W'(vcnt_reg) > EYE_W'(MAX_EYES)) ? EYE_W'(MAX_EYES)
                                                            : EYE_W'(vcnt_reg);
        thr_scaled   = PROD_W'(ear_thr_reg) * PROD_W'(eyes_clamped);
        if (!eyes_reg) begin
            judge = face_reg;
        end else if (eyes_clamped == '0) begin
            judge = 1'b0;
        end else begin
            judge = PROD_W'(sum_reg) < thr_scaled;
        end
    end

    // ring bookkeeping, valid in the update state when the old entry is on ram_rdata
    always_comb begin
        ring_full  = fill_reg == FILL_W'(HISTORY_DEPTH);
        total_drop = (ring_full && ram_rdata && total_reg != '0) ? total_reg - 1'b1
                                                                  : total_reg;
        total_upd  = total_drop + FILL_W'(closed_reg);
        fill_upd   = ring_full ? fill_reg : fill_reg + 1'b1;
        leaky_inc  = (leaky_reg == '1) ? leaky_reg : leaky_reg + 1'b1;
    end

    always_comb begin
        state_next    = state_reg;
        ear_thr_next  = ear_thr_reg;
        consec_next   = consec_reg;
        holdoff_next  = holdoff_reg;
        face_next     = face_reg;
        eyes_next     = eyes_reg;
        vcnt_next     = vcnt_reg;
        sum_next      = sum_reg;
        fill_next     = fill_reg;
        pos_next      = pos_reg;
        total_next    = total_reg;
        leaky_next    = leaky_reg;
        ticks_next    = ticks_reg;
        level_next    = level_reg;
        closed_next   = closed_reg;
        alarm_next    = alarm_reg;
        m_valid_next  = m_valid_reg;
        m_closed_next = m_closed_reg;
        m_alarm_next  = m_alarm_reg;
        m_level_next  = m_level_reg;
        ram_re        = 1'b0;
        ram_we        = 1'b0;
        div_req.start = 1'b0;
        div_req.num   = NUM_W'(PCT_SCALE) * NUM_W'(total_upd);
        div_req.den   = fill_upd;

        // the user must issue config writes only while idle; the block itself does not enforce this
        if (cfg_we) begin
            case (cfg_index)
                REG_EAR_THRESHOLD:      ear_thr_next = cfg_wdata[THR_W-1:0];
                REG_CONSECUTIVE_FRAMES: consec_next  = cfg_wdata[CNT_W-1:0];
                REG_HOLDOFF_TICKS:      holdoff_next = cfg_wdata[HOLD_W-1:0];
                default: ;
            endcase
        end

        // result taken downstream
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    face_next = s_face_present;
                    eyes_next = s_eyes_detected;
                    vcnt_next = s_valid_eye_count;
                    sum_next  = s_ratio_sum;
                    if (s_mode == MODE_TICK) begin
                        // tick only advances the saturating time base
                        if (ticks_reg != '1) begin
                            ticks_next = ticks_reg + 1'b1;
                        end
                        closed_next = 1'b0;
                        alarm_next  = 1'b0;
                        state_next  = ST_DONE;
                    end else begin
                        state_next = ST_READ;
                    end
                end
            end
            ST_READ: begin
                // fetch the slot about to be overwritten
                ram_re      = 1'b1;
                closed_next = judge;
                state_next  = ST_UPDATE;
            end
            ST_UPDATE: begin
                ram_we        = 1'b1;
                total_next    = total_upd;
                fill_next     = fill_upd;
                pos_next      = (pos_reg == IDX_W'(HISTORY_DEPTH - 1)) ? '0
                                                                      : pos_reg + 1'b1;
                div_req.start = 1'b1;
                alarm_next    = 1'b0;
                if (closed_reg) begin
                    leaky_next = leaky_inc;
                    if (leaky_inc >= consec_reg && ticks_reg >= holdoff_reg) begin
                        alarm_next = 1'b1;
                        ticks_next = '0;
                    end
                end else if (leaky_reg != '0) begin
                    leaky_next = leaky_reg - 1'b1;
                end
                state_next = ST_DIV;
            end
            ST_DIV: begin
                if (!div_rsp.busy) begin
                    level_next = div_rsp.quo[LEVEL_W-1:0];
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                // load once the output register is free or being drained
                if (!m_valid_reg || m_ready) begin
                    m_valid_next  = 1'b1;
                    m_closed_next = closed_reg;
                    m_alarm_next  = alarm_reg;
                    m_level_next  = level_reg;
                    state_next    = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            ear_thr_reg <= EAR_THRESHOLD_RST;
            consec_reg  <= CONSECUTIVE_FRAMES_RST;
            holdoff_reg <= HOLDOFF_TICKS_RST;
            fill_reg    <= '0;
            pos_reg     <= '0;
            total_reg   <= '0;
            leaky_reg   <= '0;
            ticks_reg   <= '0;
            level_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            ear_thr_reg <= ear_thr_next;
            consec_reg  <= consec_next;
            holdoff_reg <= holdoff_next;
            fill_reg    <= fill_next;
            pos_reg     <= pos_next;
            total_reg   <= total_next;
            leaky_reg   <= leaky_next;
            ticks_reg   <= ticks_next;
            level_reg   <= level_next;
            m_valid_reg <= m_valid_next;
        end
        // payload, no reset needed
        face_reg     <= face_next;
        eyes_reg     <= eyes_next;
        vcnt_reg     <= vcnt_next;
        sum_reg      <= sum_next;
        closed_reg   <= closed_next;
        alarm_reg    <= alarm_next;
        m_closed_reg <= m_closed_next;
        m_alarm_reg  <= m_alarm_next;
        m_level_reg  <= m_level_next;
    end

    assign m_valid            = m_valid_reg;
    assign m_eyes_closed      = m_closed_reg;
    assign m_drowsy_alarm     = m_alarm_reg;
    assign m_drowsiness_level = m_level_reg;

    // alarm is only raised on a closed frame
    `ECDM_ASSERT(a_alarm_needs_closed, aclk, aresetn, m_valid |-> (!m_drowsy_alarm || m_eyes_closed), "alarm without closed frame")
    // closed count can never exceed the frames held
    `ECDM_ASSERT(a_total_within_fill, aclk, aresetn, (total_reg <= fill_reg) && (fill_reg <= FILL_W'(HISTORY_DEPTH)), "history counts out of range")
    // an issued alarm restarts the holdoff count
    `ECDM_ASSERT(a_alarm_clears_ticks, aclk, aresetn, (state_reg == ST_UPDATE && alarm_next) |=> (ticks_reg == '0), "holdoff not restarted")
    // the divider is busy once the update state has started it
    `ECDM_ASSERT(a_div_started, aclk, aresetn, (state_reg == ST_UPDATE) |=> div_rsp.busy, "divider did not start")
    // level stays a percentage
    `ECDM_ASSERT(a_level_pct, aclk, aresetn, level_reg <= LEVEL_W'(PCT_SCALE), "level above full scale")

endmodule

// ----- dv/tb.sv -----
// self-checking testbench for the eye closure drowsiness monitor unit
`timescale 1ns / 100ps

module tb;
    import ecdm_pkg::*;

    // run shape
    localparam int RAND_PHASES    = 13;
    localparam int PHASE_ITEMS    = 120;
    localparam int TICK_ITEMS     = 320;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int SETTLE_CYCLES  = 40;
    localparam int EXP_DEPTH      = 16;
    localparam int SUM_MAX        = (1 << SUM_W) - 1;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

    // one request on the input side and one on the result side
    typedef struct packed {
        logic             mode;
        logic             face;
        logic             eyes;
        logic [VEC_W-1:0] cnt;
        logic [SUM_W-1:0] ratio_sum;
    } obs_t;

    typedef struct packed {
        logic               closed;
        logic               alarm;
        logic [LEVEL_W-1:0] level;
    } verdict_t;

    // directed row: typed marks a hand-written verdict, otherwise the predictor decides
    typedef struct packed {
        obs_t     obs;
        logic     typed;
        verdict_t want;
    } drow_t;

    // first block runs with reset config, second with threshold max / zero frames /
    // zero holdoff, third with threshold zero / max frames / max holdoff
    localparam int DIR_A = 11;
    localparam int DIR_B = 5;
    localparam int DIR_N = 19;
    localparam drow_t DIR_ROWS [DIR_N] = '{
        // tick straight after reset, no frame seen yet
        '{'{MODE_TICK,  1'b0, 1'b0, 3'd0, 18'd0},      1'b1, '{1'b0, 1'b0, 7'd0}},
        // face with no eyes is closed, first history entry
        '{'{MODE_FRAME, 1'b1, 1'b0, 3'd0, 18'd0},      1'b1, '{1'b1, 1'b0, 7'd100}},
        // no face and no eyes is open
        '{'{MODE_FRAME, 1'b0, 1'b0, 3'd0, 18'd0},      1'b1, '{1'b0, 1'b0, 7'd50}},
        // eyes reported but none valid is open, whatever the sum
        '{'{MODE_FRAME, 1'b1, 1'b1, 3'd0, 18'h3FFFF},  1'b1, '{1'b0, 1'b0, 7'd33}},
        // count above the eye limit is clamped, zero sum closed
        '{'{MODE_FRAME, 1'b1, 1'b1, 3'd7, 18'd0},      1'b1, '{1'b1, 1'b0, 7'd50}},
        '{'{MODE_FRAME, 1'b0, 1'b1, 3'd5, 18'd52427},  1'b0, '{1'b0, 1'b0, 7'd0}},
        // one eye just below and exactly at the threshold
        '{'{MODE_FRAME, 1'b1, 1'b1, 3'd1, 18'd13106},  1'b0, '{1'b0, 1'b0, 7'd0}},
        '{'{MODE_FRAME, 1'b1, 1'b1, 3'd1, 18'd13107},  1'b0, '{1'b0, 1'b0, 7'd0}},
        '{'{MODE_FRAME, 1'b1, 1'b1, 3'd4, 18'd52428},  1'b0, '{1'b0, 1'b0, 7'd0}},
        '{'{MODE_FRAME, 1'b1, 1'b1, 3'd4, 18'h20000},  1'b0, '{1'b0, 1'b0, 7'd0}},
        '{'{MODE_FRAME, 1'b1, 1'b1, 3'd2, 18'd26213},  1'b0, '{1'b0, 1'b0, 7'd0}},
        // zero frames and zero holdoff: any closed frame alarms
        '{'{MODE_FRAME, 1'b0, 1'b0, 3'd6, 18'd777},    1'b0, '{1'b0, 1'b0, 7'd0}},
        '{'{MODE_FRAME, 1'b1, 1'b0, 3'd0, 18'h3FFFF},  1'b0, '{1'b0, 1'b0, 7'd0}},
        '{'{MODE_FRAME, 1'b1, 1'b1, 3'd4, 18'd262140}, 1'b0, '{1'b0, 1'b0, 7'd0}},
        '{'{MODE_FRAME, 1'b1, 1'b1, 3'd4, 18'd262139}, 1'b0, '{1'b0, 1'b0, 7'd0}},
        '{'{MODE_TICK,  1'b1, 1'b1, 3'd7, 18'h3FFFF},  1'b0, '{1'b0, 1'b0, 7'd0}},
        // zero threshold: only a face without eyes can be closed
        '{'{MODE_FRAME, 1'b1, 1'b1, 3'd3, 18'd0},      1'b0, '{1'b0, 1'b0, 7'd0}},
        '{'{MODE_FRAME, 1'b1, 1'b0, 3'd0, 18'd0},      1'b0, '{1'b0, 1'b0, 7'd0}},
        '{'{MODE_TICK,  1'b0, 1'b0, 3'd0, 18'd0},      1'b0, '{1'b0, 1'b0, 7'd0}}
    };

    // clock and reset
    logic aclk    = 1'b0;
    logic aresetn = 1'b0;

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // dut input ports, all driven to known values from time zero
    logic                 s_valid           = 1'b0;
    logic                 s_ready;
    logic                 s_mode            = MODE_FRAME;
    logic                 s_face_present    = 1'b0;
    logic                 s_eyes_detected   = 1'b0;
    logic [VEC_W-1:0]     s_valid_eye_count = '0;
    logic [SUM_W-1:0]     s_ratio_sum       = '0;
    logic                 m_valid;
    logic                 m_ready           = 1'b0;
    logic                 m_eyes_closed;
    logic                 m_drowsy_alarm;
    logic [LEVEL_W-1:0]   m_drowsiness_level;
    logic                 cfg_we            = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index         = '0;
    logic [CFG_DAT_W-1:0] cfg_wdata         = '0;

    eye_closure_drowsiness_monitor_unit u_dut (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_mode             (s_mode),
        .s_face_present     (s_face_present),
        .s_eyes_detected    (s_eyes_detected),
        .s_valid_eye_count  (s_valid_eye_count),
        .s_ratio_sum        (s_ratio_sum),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_eyes_closed      (m_eyes_closed),
        .m_drowsy_alarm     (m_drowsy_alarm),
        .m_drowsiness_level (m_drowsiness_level),
        .cfg_we             (cfg_we),
        .cfg_index          (cfg_index),
        .cfg_wdata          (cfg_wdata)
    );

    // predictor copy of the config registers
    logic [THR_W-1:0]  ear_thr    = EAR_THRESHOLD_RST;
    logic [CNT_W-1:0]  min_frames = CONSECUTIVE_FRAMES_RST;
    logic [HOLD_W-1:0] holdoff    = HOLDOFF_TICKS_RST;

    // predictor copy of the monitor state
    bit closed_ring [HISTORY_DEPTH];
    int ring_fill         = 0;
    int ring_pos          = 0;
    int ring_closed       = 0;
    int leaky_cnt         = 0;
    int ticks_since_alarm = 0;
    int level_last        = 0;

    // verdicts still owed by the dut, oldest at the read index
    verdict_t exp_mem [EXP_DEPTH];
    int       exp_wr = 0;
    int       exp_rd = 0;

    int  n_err     = 0;
    int  n_frames  = 0;
    int  n_ticks   = 0;
    int  n_results = 0;
    int  n_alarms  = 0;
    int  n_cfg     = 0;
    int  idle_cnt  = 0;
    bit  rx_quiet  = 1'b0;

    function automatic int owed();
        return exp_wr - exp_rd;
    endfunction

    // closed judgment, history window, leaky counter and alarm holdoff
    function automatic verdict_t predict_perclos(input obs_t o);
        verdict_t v;
        int       eyes_n;
        logic     shut;
        v = '0;
        if (o.mode == MODE_TICK) begin
            // ticks only move the time base and repeat the last level
            if (ticks_since_alarm < 255)
                ticks_since_alarm++;
            v.level = LEVEL_W'(level_last);
            return v;
        end
        if (!o.eyes) begin
            shut = o.face;
        end else begin
            // count above the eye limit is clamped; average < thr done as sum < thr * n
            eyes_n = (int'(o.cnt) > MAX_EYES) ? MAX_EYES : int'(o.cnt);
            shut = (eyes_n != 0) && (int'(o.ratio_sum) < int'(ear_thr) * eyes_n);
        end
        // sliding history: the oldest entry drops out once the ring is full
        if (ring_fill >= HISTORY_DEPTH) begin
            if (closed_ring[ring_pos] && ring_closed > 0)
                ring_closed--;
        end else begin
            ring_fill++;
        end
        closed_ring[ring_pos] = shut;
        if (shut)
            ring_closed++;
        ring_pos   = (ring_pos + 1 >= HISTORY_DEPTH) ? 0 : ring_pos + 1;
        level_last = (PCT_SCALE * ring_closed) / ring_fill;
        v.closed   = shut;
        v.level    = LEVEL_W'(level_last);
        // leaky count; only closed frames may alarm
        if (shut) begin
            if (leaky_cnt < 65535)
                leaky_cnt++;
            if (leaky_cnt >= int'(min_frames) && ticks_since_alarm >= int'(holdoff)) begin
                v.alarm           = 1'b1;
                ticks_since_alarm = 0;
            end
        end else if (leaky_cnt > 0) begin
            leaky_cnt--;
        end
        return v;
    endfunction

    // random request: mostly frames with a chosen share closed, some ticks and noise
    function automatic obs_t make_obs(input int closed_pct, input int tick_pct);
        obs_t o;
        int   r;
        int   eyes_n;
        int   bound;
        o.mode      = MODE_FRAME;
        o.face      = 1'($urandom_range(0, 1));
        o.eyes      = 1'($urandom_range(0, 1));
        o.cnt       = VEC_W'($urandom_range(0, 7));
        o.ratio_sum = SUM_W'($urandom_range(0, SUM_MAX));
        r = $urandom_range(0, 99);
        if (r < tick_pct) begin
            o.mode = MODE_TICK;
            return o;
        end
        r = $urandom_range(0, 99);
        // fully random fields
        if (r < 8)
            return o;
        // face / no-eyes combinations
        if (r < 18) begin
            o.eyes = 1'b0;
            return o;
        end
        // well formed: valid eyes with a sum steered around the threshold
        o.eyes = 1'b1;
        o.face = ($urandom_range(0, 19) != 0);
        o.cnt  = ($urandom_range(0, 9) == 0) ? VEC_W'($urandom_range(5, 7))
                                             : VEC_W'($urandom_range(1, 4));
        eyes_n = (int'(o.cnt) > MAX_EYES) ? MAX_EYES : int'(o.cnt);
        bound  = int'(ear_thr) * eyes_n;
        if ($urandom_range(0, 99) < closed_pct) begin
            if (bound == 0)
                o.ratio_sum = '0;
            else if ($urandom_range(0, 4) == 0)
                o.ratio_sum = SUM_W'(bound - 1);
            else
                o.ratio_sum = SUM_W'($urandom_range(0, bound - 1));
        end else begin
            if ($urandom_range(0, 4) == 0)
                o.ratio_sum = SUM_W'(bound);
            else
                o.ratio_sum = SUM_W'($urandom_range(bound, SUM_MAX));
        end
        return o;
    endfunction

    // one request on the input side, with an optional idle burst in front
    task automatic send_obs(input obs_t o, input int gap_pct, input logic typed,
                            input verdict_t want);
        int       gap;
        verdict_t v;
        gap = ($urandom_range(0, 99) < gap_pct) ? $urandom_range(1, 9) : 0;
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid           <= 1'b1;
        s_mode            <= o.mode;
        s_face_present    <= o.face;
        s_eyes_detected   <= o.eyes;
        s_valid_eye_count <= o.cnt;
        s_ratio_sum       <= o.ratio_sum;
        do @(posedge aclk); while (!s_ready);
        // accepted at this edge: update the predictor and queue the verdict
        v = predict_perclos(o);
        exp_mem[exp_wr % EXP_DEPTH] = typed ? want : v;
        exp_wr++;
        if (o.mode == MODE_TICK)
            n_ticks++;
        else
            n_frames++;
    endtask

    // sender pauses until every owed verdict has come back
    task automatic drain();
        s_valid <= 1'b0;
        while (owed() != 0)
            @(posedge aclk);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(posedge aclk);
        case (idx)
            REG_EAR_THRESHOLD:      ear_thr    = data[THR_W-1:0];
            REG_CONSECUTIVE_FRAMES: min_frames = data[CNT_W-1:0];
            REG_HOLDOFF_TICKS:      holdoff    = data[HOLD_W-1:0];
            default: ;
        endcase
        n_cfg++;
    endtask

    // all three registers; holdoff may carry junk in its upper byte
    task automatic set_config(input logic [THR_W-1:0] thr, input logic [CNT_W-1:0] frames,
                              input logic [HOLD_W-1:0] hold, input bit junk_hi,
                              input bit poke_spare);
        logic [CFG_DAT_W-1:0] hold_word;
        hold_word = {(junk_hi ? 8'($urandom_range(0, 255)) : 8'd0), hold};
        cfg_write(REG_EAR_THRESHOLD, thr);
        cfg_write(REG_CONSECUTIVE_FRAMES, frames);
        cfg_write(REG_HOLDOFF_TICKS, hold_word);
        // unmapped index must leave everything alone
        if (poke_spare)
            cfg_write(REG_SPARE, CFG_DAT_W'($urandom_range(0, 65535)));
        cfg_we <= 1'b0;
    endtask

    function automatic void note_mismatch(input string what);
        n_err++;
        if (n_err <= 10)
            $display("mismatch @%0t: %s", $time, what);
    endfunction

    // result checker and no-progress watchdog
    always @(posedge aclk) begin : rx_check
        verdict_t v;
        if (aresetn && m_valid && m_ready) begin
            n_results++;
            if (m_drowsy_alarm)
                n_alarms++;
            if (owed() == 0) begin
                note_mismatch($sformatf("unexpected result closed=%0b alarm=%0b level=%0d",
                                        m_eyes_closed, m_drowsy_alarm, m_drowsiness_level));
            end else begin
                v = exp_mem[exp_rd % EXP_DEPTH];
                exp_rd++;
                if (m_eyes_closed !== v.closed || m_drowsy_alarm !== v.alarm ||
                    m_drowsiness_level !== v.level)
                    note_mismatch($sformatf(
                        "result %0d: exp closed=%0b alarm=%0b level=%0d, got %0b %0b %0d",
                        n_results, v.closed, v.alarm, v.level,
                        m_eyes_closed, m_drowsy_alarm, m_drowsiness_level));
            end
        end
        // any accept on either side counts as progress
        if ((s_valid && s_ready) || (m_valid && m_ready))
            idle_cnt <= 0;
        else
            idle_cnt <= idle_cnt + 1;
        if (idle_cnt >= WATCHDOG_LIMIT) begin
            $display("watchdog: no progress for %0d cycles, %0d results owed",
                     WATCHDOG_LIMIT, owed());
            $display("[eye_closure_drowsiness_monitor_unit] ERROR");
            $finish;
        end
    end

    // receiver backpressure: random stall bursts, none once the run gets quiet
    initial begin
        @(posedge aclk);
        m_ready <= 1'b1;
        forever begin
            if (!rx_quiet && $urandom_range(0, 99) < 25) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 9)) @(posedge aclk);
                m_ready <= 1'b1;
            end
            repeat ($urandom_range(1, 30)) @(posedge aclk);
        end
    end

    // main sequence
    initial begin : stim
        int                p;
        int                i;
        int                n_items;
        int                gap_pct;
        int                closed_pct;
        int                tick_pct;
        logic [THR_W-1:0]  thr;
        logic [CNT_W-1:0]  frames;
        logic [HOLD_W-1:0] hold;

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed rows, reset config first
        for (i = 0; i < DIR_N; i++) begin
            if (i == DIR_A) begin
                drain();
                set_config(16'hFFFF, 16'd0, 8'd0, 1'b0, 1'b1);
            end else if (i == DIR_A + DIR_B) begin
                drain();
                set_config(16'd0, 16'hFFFF, 8'hFF, 1'b1, 1'b0);
            end
            send_obs(DIR_ROWS[i].obs, 30, DIR_ROWS[i].typed, DIR_ROWS[i].want);
        end

        // random phases, config rewritten between them while idle
        for (p = 0; p < RAND_PHASES; p++) begin
            drain();
            n_items    = PHASE_ITEMS;
            tick_pct   = 12;
            closed_pct = $urandom_range(30, 95);
            gap_pct    = $urandom_range(10, 40);
            case (p)
                0: begin
                    // a frame count of one and no holdoff: alarms on most closed runs
                    thr    = THR_W'($urandom_range(10000, 20000));
                    frames = 16'd1;
                    hold   = 8'd0;
                end
                1: begin
                    // largest threshold and frame count
                    thr    = 16'hFFFF;
                    frames = 16'hFFFF;
                    hold   = HOLD_W'($urandom_range(0, 8));
                end
                2: begin
                    // long tick stretch to saturate the tick counter under max holdoff
                    thr      = THR_W'($urandom_range(10000, 20000));
                    frames   = CNT_W'($urandom_range(1, 4));
                    hold     = 8'hFF;
                    tick_pct = 90;
                    n_items  = TICK_ITEMS;
                end
                3: begin
                    thr    = 16'd0;
                    frames = CNT_W'($urandom_range(1, 10));
                    hold   = HOLD_W'($urandom_range(0, 8));
                end
                default: begin
                    thr    = ($urandom_range(0, 9) < 3) ? THR_W'($urandom_range(0, 65535))
                                                        : THR_W'($urandom_range(6000, 30000));
                    frames = ($urandom_range(0, 9) == 0) ? 16'd0
                                                         : CNT_W'($urandom_range(1, 25));
                    hold   = HOLD_W'($urandom_range(0, 8));
                end
            endcase
            // a stretch with a busy sender, and a quiet tail with no idling anywhere
            if (p == 4)
                gap_pct = 0;
            if (p == RAND_PHASES - 1) begin
                gap_pct  = 0;
                rx_quiet = 1'b1;
            end
            set_config(thr, frames, hold, p[0], 1'b0);
            for (i = 0; i < n_items; i++)
                send_obs(make_obs(closed_pct, tick_pct), gap_pct, 1'b0, '0);
        end

        drain();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (owed() != 0)
            note_mismatch($sformatf("%0d results never arrived", owed()));

        $display("run covered %0d frames and %0d ticks, %0d results checked, %0d alarms seen",
                 n_frames, n_ticks, n_results, n_alarms);
        $display("%0d config writes over %0d settings, %0d mismatches",
                 n_cfg, RAND_PHASES + 2, n_err);
        if (n_err == 0)
            $display("[eye_closure_drowsiness_monitor_unit] OK");
        else
            $display("[eye_closure_drowsiness_monitor_unit] ERROR");
        $finish;
    end

endmodule
